FILE: sv/flac_pkg.sv
`timescale 1ns / 1ps
package flac_pkg;

    localparam int ADDR_W     = 32;
    localparam int ALIGN_W    = 17;
    localparam int PAD_W      = 18;
    localparam int STATUS_W   = 3;
    localparam int CFG_ADDR_W = 4;
    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = 6;

    localparam logic [ALIGN_W-1:0] MIN_ALIGN = 17'd8;
    localparam logic [ALIGN_W-1:0] MAX_ALIGN = 17'd65536;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD     = 3'd4;

    localparam logic [1:0] REG_BASE   = 2'd0;
    localparam logic [1:0] REG_SIZE   = 2'd1;
    localparam logic [1:0] REG_POLICY = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SLOT, S_EXT, S_DIV, S_PAD, S_ACOMMIT,
        S_LSCAN, S_FSCAN, S_FDECIDE, S_FCOMMIT, S_DONE
    } flac_state_t;

    typedef enum logic [3:0] {
        OP_NOP, OP_LOAD, OP_SLOT_CLR, OP_SLOT_INC, OP_IDX_CLR, OP_DIV_START,
        OP_PAD_INIT, OP_PAD_ADD, OP_EVAL, OP_ACOMMIT, OP_FREE_LATCH, OP_FSCAN,
        OP_FCOMMIT, OP_FAIL, OP_OUT_LOAD
    } flac_op_t;

    typedef struct packed {
        flac_op_t            op;
        logic [STATUS_W-1:0] fail_code;
    } flac_cmd_t;

    typedef struct packed {
        logic is_free;
        logic bad;
        logic slot_end;
        logic slot_free;
        logic live_hit;
        logic idx_end;
        logic found;
        logic div_done;
        logic pad_small;
        logic first_fit_hit;
        logic fscan_stop;
        logic free_full;
    } flac_stat_t;

endpackage

FILE: sv/flac_if.sv
`timescale 1ns / 1ps
interface flac_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] request_size;
    logic [16:0] alignment;
    logic [31:0] data_address;

    modport source (output valid, cmd, request_size, alignment, data_address, input ready);
    modport sink   (input valid, cmd, request_size, alignment, data_address, output ready);
endinterface

interface flac_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] result_address;
    logic [31:0] block_bytes;
    logic [31:0] used_bytes;
    logic [31:0] peak_bytes;

    modport source (output valid, status, result_address, block_bytes, used_bytes,
                    peak_bytes, input ready);
    modport sink   (input valid, status, result_address, block_bytes, used_bytes,
                    peak_bytes, output ready);
endinterface

FILE: sv/flac_rem.sv
`timescale 1ns / 1ps
module flac_rem
    import flac_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [ADDR_W-1:0]  dividend,
    input  logic [ALIGN_W-1:0] divisor,
    output logic               done,
    output logic [ALIGN_W-1:0] rem
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [ADDR_W-1:0]    dvd_reg, dvd_next;
    logic [ALIGN_W-1:0]   dsr_reg, dsr_next;
    logic [ALIGN_W-1:0]   rem_reg, rem_next;
    logic [ALIGN_W:0]     trial;

    // restoring remainder, one dividend bit per cycle
    assign trial = {rem_reg, dvd_reg[ADDR_W-1]};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next = DIV_CNT_W'(DIV_STEPS);
            dvd_next = dividend;
            dsr_next = divisor;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            dvd_next = {dvd_reg[ADDR_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
                rem_next = ALIGN_W'(trial - {1'b0, dsr_reg});
            else
                rem_next = ALIGN_W'(trial);
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: sv/flac_dp.sv
`timescale 1ns / 1ps
module flac_dp
    import flac_pkg::*;
#(
    parameter int MAX_FREE_EXTENTS  = 16,
    parameter int MAX_LIVE_BLOCKS   = 16,
    parameter int HEADER_BYTES      = 16,
    parameter int MIN_REQUEST_BYTES = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  flac_cmd_t           cmd,
    output flac_stat_t          stat,
    input  logic                in_cmd,
    input  logic [ADDR_W-1:0]   in_request_size,
    input  logic [ALIGN_W-1:0]  in_alignment,
    input  logic [ADDR_W-1:0]   in_data_address,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_idx,
    input  logic [31:0]         cfg_data,
    output logic [31:0]         cfg_rdata,
    output logic [STATUS_W-1:0] out_status,
    output logic [ADDR_W-1:0]   out_result_address,
    output logic [ADDR_W-1:0]   out_block_bytes,
    output logic [ADDR_W-1:0]   out_used_bytes,
    output logic [ADDR_W-1:0]   out_peak_bytes
);

    localparam int N       = MAX_FREE_EXTENTS;
    localparam int L       = MAX_LIVE_BLOCKS;
    localparam int EIDX_W  = $clog2(N);
    localparam int ECNT_W  = $clog2(N + 1);
    localparam int SIDX_W  = (L > 1) ? $clog2(L) : 1;
    localparam int SCNT_W  = $clog2(L + 1);

    // request and config
    logic                cmd_reg, cmd_next;
    logic [ADDR_W-1:0]   size_reg, size_next;
    logic [ALIGN_W-1:0]  align_reg, align_next;
    logic [ADDR_W-1:0]   daddr_reg, daddr_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [ADDR_W-1:0]   region_reg, region_next;
    logic                policy_reg, policy_next;

    // extent table
    logic [ADDR_W-1:0]   ext_start_reg [N];
    logic [ADDR_W-1:0]   ext_start_next [N];
    logic [ADDR_W-1:0]   ext_len_reg [N];
    logic [ADDR_W-1:0]   ext_len_next [N];
    logic [ECNT_W-1:0]   ext_cnt_reg, ext_cnt_next;

    // live table
    logic [ADDR_W-1:0]   live_addr_reg [L];
    logic [ADDR_W-1:0]   live_start_reg [L];
    logic [ADDR_W-1:0]   live_len_reg [L];
    logic [L-1:0]        live_valid_reg, live_valid_next;
    logic                live_we;
    logic [ADDR_W-1:0]   live_addr_next, live_start_next, live_len_next;

    logic [ADDR_W-1:0]   used_reg, used_next;
    logic [ADDR_W-1:0]   peak_reg, peak_next;

    // scan state
    logic [SCNT_W-1:0]   slot_reg, slot_next;
    logic [ECNT_W-1:0]   idx_reg, idx_next;
    logic [PAD_W-1:0]    pad_reg, pad_next;
    logic                found_reg, found_next;
    logic [EIDX_W-1:0]   best_reg, best_next;
    logic [PAD_W-1:0]    best_pad_reg, best_pad_next;
    logic [ADDR_W-1:0]   best_slack_reg, best_slack_next;
    logic [ADDR_W-1:0]   bs_reg, bs_next;
    logic [ADDR_W-1:0]   bl_reg, bl_next;
    logic [ADDR_W:0]     prev_end_reg, prev_end_next;
    logic [ADDR_W-1:0]   prev_len_reg, prev_len_next;
    logic [ECNT_W-1:0]   pos_reg, pos_next;
    logic                mprev_reg, mprev_next;
    logic                mnext_reg, mnext_next;

    // staged result and output registers
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [ADDR_W-1:0]   raddr_reg, raddr_next;
    logic [ADDR_W-1:0]   rbytes_reg, rbytes_next;
    logic [STATUS_W-1:0] o_status_reg, o_status_next;
    logic [ADDR_W-1:0]   o_addr_reg, o_addr_next;
    logic [ADDR_W-1:0]   o_bytes_reg, o_bytes_next;
    logic [ADDR_W-1:0]   o_used_reg, o_used_next;
    logic [ADDR_W-1:0]   o_peak_reg, o_peak_next;

    // combinational
    logic [SIDX_W-1:0]   slot_i;
    logic [EIDX_W-1:0]   idx_i, pos_i;
    logic [ADDR_W-1:0]   cur_start, cur_len, best_start, pos_len;
    logic [ADDR_W:0]     need;
    logic                fits;
    logic [ADDR_W-1:0]   slack;
    logic                take;
    logic [ADDR_W-1:0]   req32, alloc_addr, used_add;
    logic                fstop, mprev_now, mnext_now;
    logic                reinit;
    logic [ADDR_W-1:0]   region_new;
    logic                div_done;
    logic [ALIGN_W-1:0]  div_rem;
    logic                div_start;
    logic [ECNT_W-1:0]   jw;

    assign slot_i     = slot_reg[SIDX_W-1:0];
    assign idx_i      = idx_reg[EIDX_W-1:0];
    assign pos_i      = pos_reg[EIDX_W-1:0];
    assign cur_start  = ext_start_reg[idx_i];
    assign cur_len    = ext_len_reg[idx_i];
    assign best_start = ext_start_reg[best_reg];
    assign pos_len    = ext_len_reg[pos_i];

    assign need  = {1'b0, size_reg} + {{(ADDR_W + 1 - PAD_W){1'b0}}, pad_reg};
    assign fits  = ({1'b0, cur_len} >= need);
    assign slack = cur_len - need[ADDR_W-1:0];
    assign take  = fits && (!found_reg || (policy_reg && (slack < best_slack_reg)));

    assign req32      = size_reg + {{(ADDR_W - PAD_W){1'b0}}, best_pad_reg};
    assign alloc_addr = base_reg + best_start + {{(ADDR_W - PAD_W){1'b0}}, best_pad_reg};
    assign used_add   = used_reg + req32;

    assign fstop     = (idx_reg == ext_cnt_reg) || (cur_start > bs_reg);
    assign mnext_now = (idx_reg != ext_cnt_reg)
                       && (({1'b0, bs_reg} + {1'b0, bl_reg}) == {1'b0, cur_start});
    assign mprev_now = (idx_reg != '0) && (prev_end_reg == {1'b0, bs_reg});

    assign reinit     = cfg_we && (cfg_idx != 2'd3);
    assign region_new = (cfg_idx == REG_SIZE) ? cfg_data : region_reg;
    assign div_start  = (cmd.op == OP_DIV_START);

    flac_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (base_reg + cur_start),
        .divisor  (align_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_comb
    begin
        stat.is_free       = (cmd_reg != CMD_ALLOC);
        stat.bad           = (align_reg < MIN_ALIGN) || (align_reg > MAX_ALIGN)
                             || (size_reg < ADDR_W'(MIN_REQUEST_BYTES));
        stat.slot_end      = (slot_reg == SCNT_W'(L));
        stat.slot_free     = !live_valid_reg[slot_i];
        stat.live_hit      = live_valid_reg[slot_i] && (live_addr_reg[slot_i] == daddr_reg);
        stat.idx_end       = (idx_reg == ext_cnt_reg);
        stat.found         = found_reg;
        stat.div_done      = div_done;
        stat.pad_small     = (pad_reg < PAD_W'(HEADER_BYTES));
        stat.first_fit_hit = fits && !policy_reg;
        stat.fscan_stop    = fstop;
        stat.free_full     = !mprev_reg && !mnext_reg && (ext_cnt_reg >= ECNT_W'(N));
    end

    always_comb
    begin
        case (cfg_idx)
            REG_BASE:   cfg_rdata = base_reg;
            REG_SIZE:   cfg_rdata = region_reg;
            REG_POLICY: cfg_rdata = {31'd0, policy_reg};
            default:    cfg_rdata = '0;
        endcase
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        size_next       = size_reg;
        align_next      = align_reg;
        daddr_next      = daddr_reg;
        base_next       = base_reg;
        region_next     = region_reg;
        policy_next     = policy_reg;
        ext_start_next  = ext_start_reg;
        ext_len_next    = ext_len_reg;
        ext_cnt_next    = ext_cnt_reg;
        live_valid_next = live_valid_reg;
        live_we         = 1'b0;
        live_addr_next  = alloc_addr;
        live_start_next = best_start;
        live_len_next   = req32;
        used_next       = used_reg;
        peak_next       = peak_reg;
        slot_next       = slot_reg;
        idx_next        = idx_reg;
        pad_next        = pad_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_pad_next   = best_pad_reg;
        best_slack_next = best_slack_reg;
        bs_next         = bs_reg;
        bl_next         = bl_reg;
        prev_end_next   = prev_end_reg;
        prev_len_next   = prev_len_reg;
        pos_next        = pos_reg;
        mprev_next      = mprev_reg;
        mnext_next      = mnext_reg;
        st_next         = st_reg;
        raddr_next      = raddr_reg;
        rbytes_next     = rbytes_reg;
        o_status_next   = o_status_reg;
        o_addr_next     = o_addr_reg;
        o_bytes_next    = o_bytes_reg;
        o_used_next     = o_used_reg;
        o_peak_next     = o_peak_reg;
        jw              = '0;

        case (cmd.op)
            OP_LOAD:
            begin
                cmd_next   = in_cmd;
                size_next  = in_request_size;
                align_next = in_alignment;
                daddr_next = in_data_address;
            end
            OP_SLOT_CLR:  slot_next = '0;
            OP_SLOT_INC:  slot_next = slot_reg + 1'b1;
            OP_IDX_CLR:
            begin
                idx_next   = '0;
                found_next = 1'b0;
            end
            OP_PAD_INIT:  pad_next = {1'b0, align_reg} - {1'b0, div_rem};
            OP_PAD_ADD:   pad_next = pad_reg + {1'b0, align_reg};
            OP_EVAL:
            begin
                if (take)
                begin
                    found_next      = 1'b1;
                    best_next       = idx_i;
                    best_pad_next   = pad_reg;
                    best_slack_next = slack;
                end
                idx_next = idx_reg + 1'b1;
            end
            OP_ACOMMIT:
            begin
                live_we                 = 1'b1;
                live_valid_next[slot_i] = 1'b1;
                if (best_slack_reg != '0)
                begin
                    ext_start_next[best_reg] = best_start + req32;
                    ext_len_next[best_reg]   = best_slack_reg;
                end
                else
                begin
                    for (int j = 0; j < N - 1; j++)
                    begin
                        if (EIDX_W'(j) >= best_reg)
                        begin
                            ext_start_next[j] = ext_start_reg[j + 1];
                            ext_len_next[j]   = ext_len_reg[j + 1];
                        end
                    end
                    ext_cnt_next = ext_cnt_reg - 1'b1;
                end
                used_next = used_add;
                if (used_add > peak_reg)
                    peak_next = used_add;
                st_next     = ST_OK;
                raddr_next  = alloc_addr;
                rbytes_next = req32;
            end
            OP_FREE_LATCH:
            begin
                bs_next  = live_start_reg[slot_i];
                bl_next  = live_len_reg[slot_i];
                idx_next = '0;
            end
            OP_FSCAN:
            begin
                if (fstop)
                begin
                    pos_next   = idx_reg;
                    mprev_next = mprev_now;
                    mnext_next = mnext_now;
                end
                else
                begin
                    prev_end_next = {1'b0, cur_start} + {1'b0, cur_len};
                    prev_len_next = cur_len;
                    idx_next      = idx_reg + 1'b1;
                end
            end
            OP_FCOMMIT:
            begin
                live_valid_next[slot_i] = 1'b0;
                for (int j = 0; j < N; j++)
                begin
                    jw = ECNT_W'(j);
                    if (mprev_reg && mnext_reg)
                    begin
                        if (jw == pos_reg - 1'b1)
                            ext_len_next[j] = prev_len_reg + bl_reg + pos_len;
                        else if ((jw >= pos_reg) && (j < N - 1))
                        begin
                            ext_start_next[j] = ext_start_reg[(j + 1) % N];
                            ext_len_next[j]   = ext_len_reg[(j + 1) % N];
                        end
                    end
                    else if (mprev_reg)
                    begin
                        if (jw == pos_reg - 1'b1)
                            ext_len_next[j] = prev_len_reg + bl_reg;
                    end
                    else if (mnext_reg)
                    begin
                        if (jw == pos_reg)
                        begin
                            ext_start_next[j] = bs_reg;
                            ext_len_next[j]   = pos_len + bl_reg;
                        end
                    end
                    else
                    begin
                        if (jw == pos_reg)
                        begin
                            ext_start_next[j] = bs_reg;
                            ext_len_next[j]   = bl_reg;
                        end
                        else if ((jw > pos_reg) && (j > 0))
                        begin
                            ext_start_next[j] = ext_start_reg[(j + N - 1) % N];
                            ext_len_next[j]   = ext_len_reg[(j + N - 1) % N];
                        end
                    end
                end
                if (mprev_reg && mnext_reg)
                    ext_cnt_next = ext_cnt_reg - 1'b1;
                else if (!mprev_reg && !mnext_reg)
                    ext_cnt_next = ext_cnt_reg + 1'b1;
                used_next   = (used_reg >= bl_reg) ? (used_reg - bl_reg) : '0;
                st_next     = ST_OK;
                raddr_next  = '0;
                rbytes_next = bl_reg;
            end
            OP_FAIL:
            begin
                st_next     = cmd.fail_code;
                raddr_next  = '0;
                rbytes_next = '0;
            end
            OP_OUT_LOAD:
            begin
                o_status_next = st_reg;
                o_addr_next   = raddr_reg;
                o_bytes_next  = rbytes_reg;
                o_used_next   = used_reg;
                o_peak_next   = peak_reg;
            end
            default: ;
        endcase

        // user keeps register writes to idle (unchecked); idx 0-2 reset region
        if (reinit)
        begin
            case (cfg_idx)
                REG_BASE:   base_next   = cfg_data;
                REG_SIZE:   region_next = cfg_data;
                REG_POLICY: policy_next = cfg_data[0];
                default: ;
            endcase
            ext_start_next[0] = '0;
            ext_len_next[0]   = region_new;
            ext_cnt_next      = ECNT_W'(1);
            live_valid_next   = '0;
            used_next         = '0;
            peak_next         = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg         <= '0;
            region_reg       <= 32'd65536;
            policy_reg       <= 1'b0;
            for (int j = 0; j < N; j++)
            begin
                ext_start_reg[j] <= '0;
                ext_len_reg[j]   <= (j == 0) ? 32'd65536 : 32'd0;
            end
            ext_cnt_reg      <= ECNT_W'(1);
            live_valid_reg   <= '0;
            used_reg         <= '0;
            peak_reg         <= '0;
        end
        else
        begin
            base_reg         <= base_next;
            region_reg       <= region_next;
            policy_reg       <= policy_next;
            for (int j = 0; j < N; j++)
            begin
                ext_start_reg[j] <= ext_start_next[j];
                ext_len_reg[j]   <= ext_len_next[j];
            end
            ext_cnt_reg      <= ext_cnt_next;
            live_valid_reg   <= live_valid_next;
            used_reg         <= used_next;
            peak_reg         <= peak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (live_we)
        begin
            live_addr_reg[slot_i]  <= live_addr_next;
            live_start_reg[slot_i] <= live_start_next;
            live_len_reg[slot_i]   <= live_len_next;
        end
        cmd_reg        <= cmd_next;
        size_reg       <= size_next;
        align_reg      <= align_next;
        daddr_reg      <= daddr_next;
        slot_reg       <= slot_next;
        idx_reg        <= idx_next;
        pad_reg        <= pad_next;
        found_reg      <= found_next;
        best_reg       <= best_next;
        best_pad_reg   <= best_pad_next;
        best_slack_reg <= best_slack_next;
        bs_reg         <= bs_next;
        bl_reg         <= bl_next;
        prev_end_reg   <= prev_end_next;
        prev_len_reg   <= prev_len_next;
        pos_reg        <= pos_next;
        mprev_reg      <= mprev_next;
        mnext_reg      <= mnext_next;
        st_reg         <= st_next;
        raddr_reg      <= raddr_next;
        rbytes_reg     <= rbytes_next;
        o_status_reg   <= o_status_next;
        o_addr_reg     <= o_addr_next;
        o_bytes_reg    <= o_bytes_next;
        o_used_reg     <= o_used_next;
        o_peak_reg     <= o_peak_next;
    end

    assign out_status         = o_status_reg;
    assign out_result_address = o_addr_reg;
    assign out_block_bytes    = o_bytes_reg;
    assign out_used_bytes     = o_used_reg;
    assign out_peak_bytes     = o_peak_reg;

endmodule

FILE: sv/flac_ctrl.sv
`timescale 1ns / 1ps
module flac_ctrl
    import flac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output flac_cmd_t  cmd,
    input  flac_stat_t stat
);

    flac_state_t state_reg, state_next;
    logic        ovalid_reg, ovalid_next;
    logic        out_load;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (in_valid) state_next = S_CHECK;
            S_CHECK:
            begin
                if (stat.is_free)
                    state_next = S_LSCAN;
                else if (stat.bad)
                    state_next = S_DONE;
                else
                    state_next = S_SLOT;
            end
            S_SLOT:
            begin
                if (stat.slot_end)
                    state_next = S_DONE;
                else if (stat.slot_free)
                    state_next = S_EXT;
            end
            S_EXT:
            begin
                if (stat.idx_end)
                    state_next = stat.found ? S_ACOMMIT : S_DONE;
                else
                    state_next = S_DIV;
            end
            S_DIV:     if (stat.div_done) state_next = S_PAD;
            S_PAD:
            begin
                if (!stat.pad_small)
                    state_next = stat.first_fit_hit ? S_ACOMMIT : S_EXT;
            end
            S_ACOMMIT: state_next = S_DONE;
            S_LSCAN:
            begin
                if (stat.slot_end)
                    state_next = S_DONE;
                else if (stat.live_hit)
                    state_next = S_FSCAN;
            end
            S_FSCAN:   if (stat.fscan_stop) state_next = S_FDECIDE;
            S_FDECIDE: state_next = stat.free_full ? S_DONE : S_FCOMMIT;
            S_FCOMMIT: state_next = S_DONE;
            S_DONE:    if (!ovalid_reg || out_ready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op        = OP_NOP;
        cmd.fail_code = ST_OK;
        in_ready      = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = OP_LOAD;
            end
            S_CHECK:
            begin
                if (!stat.is_free && stat.bad)
                begin
                    cmd.op        = OP_FAIL;
                    cmd.fail_code = ST_BAD;
                end
                else
                    cmd.op = OP_SLOT_CLR;
            end
            S_SLOT:
            begin
                if (stat.slot_end)
                begin
                    cmd.op        = OP_FAIL;
                    cmd.fail_code = ST_FULL;
                end
                else if (stat.slot_free)
                    cmd.op = OP_IDX_CLR;
                else
                    cmd.op = OP_SLOT_INC;
            end
            S_EXT:
            begin
                if (stat.idx_end && !stat.found)
                begin
                    cmd.op        = OP_FAIL;
                    cmd.fail_code = ST_NO_FIT;
                end
                else if (!stat.idx_end)
                    cmd.op = OP_DIV_START;
            end
            S_DIV:     if (stat.div_done) cmd.op = OP_PAD_INIT;
            S_PAD:     cmd.op = stat.pad_small ? OP_PAD_ADD : OP_EVAL;
            S_ACOMMIT: cmd.op = OP_ACOMMIT;
            S_LSCAN:
            begin
                if (stat.slot_end)
                begin
                    cmd.op        = OP_FAIL;
                    cmd.fail_code = ST_UNKNOWN;
                end
                else if (stat.live_hit)
                    cmd.op = OP_FREE_LATCH;
                else
                    cmd.op = OP_SLOT_INC;
            end
            S_FSCAN:   cmd.op = OP_FSCAN;
            S_FDECIDE:
            begin
                if (stat.free_full)
                begin
                    cmd.op        = OP_FAIL;
                    cmd.fail_code = ST_FULL;
                end
            end
            S_FCOMMIT: cmd.op = OP_FCOMMIT;
            S_DONE:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    cmd.op   = OP_OUT_LOAD;
                    out_load = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        if (out_load)
            ovalid_next = 1'b1;
        else if (out_ready)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

endmodule

FILE: sv/free_list_allocator_coalescing.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake          Payload
// req      in   valid/ready        cmd, request_size, alignment, data_address
// rsp      out  valid/ready        status, result_address, block_bytes,
//                                  used_bytes, peak_bytes
// apb      in   psel/penable, wr   paddr (4*index), pwdata, prdata; pready tied high
//
// One request at a time. Alloc: a setup step, a probe of the live slots for a
// free one, then per extent a start, the serial remainder by alignment, a
// padding fixup and an evaluate; first fit stops at the first hit. Free: a probe
// of the live slots, a scan of the extents up to the insertion point, then a
// decide step and a commit.
// rst_n is asynchronous; state after reset is one free extent of 65536 bytes.
// The result sits in an output register; a new request is taken while it waits,
// and its own result is held back until the previous one has been taken.
module free_list_allocator_coalescing
    import flac_pkg::*;
#(
    parameter int MAX_FREE_EXTENTS  = 16,
    parameter int MAX_LIVE_BLOCKS   = 16,
    parameter int HEADER_BYTES      = 16,
    parameter int MIN_REQUEST_BYTES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    flac_req_if.sink              req,
    flac_rsp_if.source            rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    flac_cmd_t  cmd;
    flac_stat_t stat;
    logic       cfg_we;

    // register write lands on the access phase
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    flac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    flac_dp #(
        .MAX_FREE_EXTENTS  (MAX_FREE_EXTENTS),
        .MAX_LIVE_BLOCKS   (MAX_LIVE_BLOCKS),
        .HEADER_BYTES      (HEADER_BYTES),
        .MIN_REQUEST_BYTES (MIN_REQUEST_BYTES)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .in_cmd             (req.cmd),
        .in_request_size    (req.request_size),
        .in_alignment       (req.alignment),
        .in_data_address    (req.data_address),
        .cfg_we             (cfg_we),
        .cfg_idx            (paddr[3:2]),
        .cfg_data           (pwdata),
        .cfg_rdata          (prdata),
        .out_status         (rsp.status),
        .out_result_address (rsp.result_address),
        .out_block_bytes    (rsp.block_bytes),
        .out_used_bytes     (rsp.used_bytes),
        .out_peak_bytes     (rsp.peak_bytes)
    );

endmodule
